[rtl/core/esdt_pkg.sv]
// Shared types and constants of the epoch-stamp dirty tracker.
`default_nettype none
package esdt_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int ACT_W      = 9;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 9'd256;

    // Register index, taken from paddr[2].
    localparam logic REG_ACTIVE_ENTRIES = 1'b0;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_ADVANCE    = 3'd0;
    localparam t_kind KIND_TEST       = 3'd1;
    localparam t_kind KIND_QUERY      = 3'd2;
    localparam t_kind KIND_MARK_CLEAN = 3'd3;
    localparam t_kind KIND_MARK_DIRTY = 3'd4;
    localparam t_kind KIND_CLEAN_ALL  = 3'd5;

endpackage
`default_nettype wire

[rtl/core/esdt_ram.sv]
// Generic single-port RAM with a registered read.
`default_nettype none
module esdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_re,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    output logic      [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/core/esdt_cfg.sv]
// APB register file holding the active entry count.
`default_nettype none
module esdt_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [esdt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [esdt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [esdt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [esdt_pkg::ACT_W-1:0]        o_active_entries
);
    import esdt_pkg::*;

    logic [ACT_W-1:0] r_active;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (wr_hit) begin
            r_active <= pwdata[ACT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACTIVE_ENTRIES) begin
            prdata = {{(CFG_DATA_W-ACT_W){1'b0}}, r_active};
        end else begin
            prdata = '0;
        end
    end

    assign o_active_entries = r_active;

endmodule
`default_nettype wire

[rtl/core/epoch_stamp_dirty_tracker.sv]
// Top level of the epoch-stamp dirty tracker: sequencer, epoch and stamp memory.
//
// The tracker keeps one stamp per entry in a single-port RAM and the current
// epoch in a register; an entry is clean while its stamp equals the epoch and
// dirty while the stamp is below it. Each input beat carries one operation in
// tuser and yields exactly one output beat. A single-entry operation (test,
// query, mark clean, mark dirty) and an advance first read the stamp from the
// RAM and then compare and write it back; no new beat is accepted until the
// last one commits, and a commit waits while the output register holds a
// result the sink has not taken. Clean all answers at once, then the RAM port
// sweeps the first min(active_entries, DEPTH, 256) entries, one entry per
// cycle (a count of 0 acts as 1), and the next beat waits until the sweep ends.
// After reset the same port clears all min(DEPTH, 256) stamps and no beat is
// accepted until it is done; configuration writes are taken at any time. Only
// the first 256 entries can ever be addressed, so the RAM holds at most that
// many. A finished result is held in the output register until the sink takes it.
`default_nettype none
module epoch_stamp_dirty_tracker #(
    parameter int DEPTH       = 256,
    parameter int STAMP_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] entry_index, [8] clean_on_test, [15:9] zero.
    input  wire logic [15:0]                      s_axis_tdata,
    // [2:0] kind.
    input  wire logic [2:0]                       s_axis_tuser,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] answer, [1] index_ok, [7:2] zero.
    output logic      [7:0]                       m_axis_tdata,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [esdt_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [esdt_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [esdt_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import esdt_pkg::*;

    // Entries beyond 255 can never be addressed, so the RAM stops there.
    localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [ACT_W-1:0] MEM_DEPTH_C = ACT_W'(MEM_DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR   = AW'(MEM_DEPTH - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [ACT_W-1:0] active_entries;

    logic [1:0]             r_state, n_state;
    logic [STAMP_WIDTH-1:0] r_epoch, n_epoch;
    logic [AW-1:0]          r_sweep_addr, n_sweep_addr;
    logic [AW-1:0]          r_sweep_last, n_sweep_last;

    // Item held between accept and commit.
    t_kind                  r_kind;
    logic [AW-1:0]          r_addr;
    logic                   r_wipe;
    logic                   r_ok;
    logic [AW-1:0]          r_last;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_answer, n_out_answer;
    logic                   r_out_ok;

    logic                   in_acc;
    logic                   commit;
    logic [7:0]             in_idx;
    logic [ACT_W-1:0]       act_min1;
    logic [ACT_W-1:0]       cnt_eff;
    logic [ACT_W-1:0]       cnt_last;
    logic                   in_ok;

    logic [STAMP_WIDTH-1:0] stamp;
    logic                   stamp_lt;
    logic                   stamp_eq;
    logic                   ram_re;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [STAMP_WIDTH-1:0] ram_wdata;
    logic                   item_we;
    logic [STAMP_WIDTH-1:0] item_wdata;
    logic                   item_ans;

    esdt_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_active_entries (active_entries)
    );

    esdt_ram #(
        .WIDTH (STAMP_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_stamps (
        .i_clk   (i_clk),
        .i_re    (ram_re),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (stamp)
    );

    // Input decode. A count of zero acts as one, and the sweep never runs past
    // the RAM, since the entries above it cannot be read back.
    assign in_idx   = s_axis_tdata[7:0];
    assign act_min1 = (active_entries == '0) ? ACT_W'(1) : active_entries;
    assign cnt_eff  = (act_min1 > MEM_DEPTH_C) ? MEM_DEPTH_C : act_min1;
    assign cnt_last = cnt_eff - ACT_W'(1);
    assign in_ok    = ({1'b0, in_idx} < act_min1) && ({24'd0, in_idx} < 32'(DEPTH));

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    // The result leaves only when the output register is free or draining.
    assign commit        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign stamp_lt = stamp < r_epoch;
    assign stamp_eq = stamp == r_epoch;

    // Read-modify-write of the addressed stamp.
    always_comb begin
        item_we    = 1'b0;
        item_wdata = r_epoch;
        item_ans   = 1'b0;
        n_epoch    = r_epoch;
        case (r_kind)
            KIND_ADVANCE: begin
                n_epoch = r_epoch + STAMP_WIDTH'(1);
            end
            KIND_TEST: begin
                item_ans = r_ok && stamp_lt;
                item_we  = r_ok && stamp_lt && r_wipe;
            end
            KIND_QUERY: begin
                item_ans = r_ok && stamp_eq;
            end
            KIND_MARK_CLEAN: begin
                item_ans = r_ok;
                item_we  = r_ok;
            end
            KIND_MARK_DIRTY: begin
                item_ans   = r_ok;
                item_we    = r_ok;
                item_wdata = '0;
            end
            default: begin
            end
        endcase
        if (!commit) begin
            n_epoch = r_epoch;
        end
    end

    // The RAM port is shared by the reset clear, the clean-all sweep, the
    // read at accept and the write-back at commit; the sequencer never lets
    // two of them meet in one cycle.
    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = item_wdata;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_re   = in_acc;
                ram_addr = in_idx[AW-1:0];
            end
            S_EXEC: begin
                ram_we = commit && item_we;
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep_addr;
                ram_wdata = r_epoch;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_answer = r_out_answer;
        case (r_state)
            S_CLEAR, S_SWEEP: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (r_sweep_addr == r_sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_out_valid  = 1'b1;
                    n_out_answer = item_ans;
                    if (r_kind == KIND_CLEAN_ALL) begin
                        n_state      = S_SWEEP;
                        n_sweep_addr = '0;
                        n_sweep_last = r_last;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_epoch      <= '0;
            r_sweep_addr <= '0;
            r_sweep_last <= LAST_ADDR;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_epoch      <= n_epoch;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_last <= n_sweep_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= s_axis_tuser;
            r_addr <= in_idx[AW-1:0];
            r_wipe <= s_axis_tdata[8];
            r_ok   <= in_ok;
            r_last <= cnt_last[AW-1:0];
        end
        if (commit) begin
            r_out_ok <= r_ok;
        end
        r_out_answer <= n_out_answer;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_ok, r_out_answer};

    // An accepted beat always moves on to the compare and write-back cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted beat did not enter the execute cycle");

    // The epoch moves only when an advance commits.
    a_epoch_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_epoch != $past(r_epoch))) |->
            $past(commit && (r_kind == KIND_ADVANCE)))
        else $error("epoch changed outside an advance");

    // A clean-all sweep never runs past the last active entry.
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_sweep_addr <= r_sweep_last))
        else $error("sweep address beyond the active entries");

endmodule
`default_nettype wire
